// ===== sv/drfm_pkg.sv =====
// ----------------------------------------------------------------------------
// drfm_pkg: shared types and constants of the display register and frame memory
// Address map, access size codes and the decoded access record.
// ----------------------------------------------------------------------------
package drfm_pkg;

	// default store geometry
	localparam int COLOUR_ROWS_DEF    = 32;
	localparam int COLOUR_COLUMNS_DEF = 32;
	localparam int MONO_ROWS_DEF      = 32;

	// largest store the geometry ranges allow, sets the row field width
	localparam int MAX_STORE_WORDS = 64 * 64;
	localparam int ROW_W           = $clog2(MAX_STORE_WORDS);

	// address map
	localparam logic [15:0] COLOUR_BASE    = 16'h4000;
	localparam logic [15:0] MONO_BASE      = 16'h8000;
	localparam logic [15:0] SEG_RIGHT_ADDR = 16'h0010;
	localparam logic [15:0] SEG_LEFT_ADDR  = 16'h0011;

	typedef enum logic [1:0] {
		SIZE_BYTE = 2'd0,
		SIZE_HALF = 2'd1,
		SIZE_WORD = 2'd2,
		SIZE_RSVD = 2'd3
	} size_t;

	typedef enum logic {
		KIND_READ  = 1'b0,
		KIND_WRITE = 1'b1
	} kind_t;

	// one decoded bus access, per byte-lane bank
	typedef struct packed {
		logic                       rd;
		logic                       wr;
		logic                       seg_r;
		logic                       seg_l;
		logic                       seg_wide;
		logic                       use_mono;
		logic [1:0]                 off_lo;
		logic [3:0]                 bank_act;
		logic [3:0][ROW_W-1:0]      bank_row;
		logic [3:0][7:0]            bank_wdata;
	} acc_t;

endpackage

// ===== sv/drfm_byte_ram.sv =====
// ----------------------------------------------------------------------------
// drfm_byte_ram: one byte-lane bank of a store
// Single-port synchronous memory, read data registered.
// ----------------------------------------------------------------------------
module drfm_byte_ram import drfm_pkg::*; #(
	parameter int DEPTH = COLOUR_ROWS_DEF * COLOUR_COLUMNS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// write, or read into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== sv/drfm_decode.sv =====
// ----------------------------------------------------------------------------
// drfm_decode: address decode of one bus access
// Selects segment bytes or a store and maps the access onto four byte lanes.
// ----------------------------------------------------------------------------
module drfm_decode import drfm_pkg::*; #(
	parameter int COLOUR_WORDS = COLOUR_ROWS_DEF * COLOUR_COLUMNS_DEF,
	parameter int MONO_WORDS   = MONO_ROWS_DEF
) (
	input  logic        kind,
	input  logic [15:0] address,
	input  logic [1:0]  size_code,
	input  logic [31:0] write_data,
	output acc_t        acc
);

	localparam logic [16:0] COLOUR_BYTES = 17'(COLOUR_WORDS * 4);
	localparam logic [16:0] MONO_BYTES   = 17'(MONO_WORDS * 4);
	localparam logic [15:0] COLOUR_LIM   = 16'(COLOUR_WORDS);
	localparam logic [15:0] MONO_LIM     = 16'(MONO_WORDS);

	always_comb begin
		logic [15:0] c_off;
		logic [15:0] m_off;
		logic [15:0] off;
		logic [15:0] words;
		logic        hit_colour;
		logic        hit_mono;
		logic        size_ok;
		logic [1:0]  pos;
		logic [14:0] row;
		logic        in_size;

		// store window from the start address only
		c_off      = address - COLOUR_BASE;
		m_off      = address - MONO_BASE;
		hit_colour = (address >= COLOUR_BASE) && ({1'b0, c_off} < COLOUR_BYTES);
		hit_mono   = !hit_colour && (address >= MONO_BASE) && ({1'b0, m_off} < MONO_BYTES);
		off        = hit_colour ? c_off : m_off;
		words      = hit_colour ? COLOUR_LIM : MONO_LIM;
		size_ok    = size_t'(size_code) != SIZE_RSVD;

		acc          = '0;
		acc.rd       = kind_t'(kind) == KIND_READ;
		acc.wr       = (kind_t'(kind) == KIND_WRITE) && size_ok;
		acc.seg_r    = size_ok && (address == SEG_RIGHT_ADDR);
		acc.seg_l    = size_ok && (address == SEG_LEFT_ADDR);
		acc.seg_wide = (size_t'(size_code) == SIZE_HALF) || (size_t'(size_code) == SIZE_WORD);
		acc.use_mono = hit_mono;
		acc.off_lo   = off[1:0];

		// per bank: which access byte lands here, in which row
		for (int b = 0; b < 4; b++) begin
			pos = 2'(b) - off[1:0];
			row = 15'(off[15:2]) + 15'(2'(b) < off[1:0]);
			unique case (size_t'(size_code))
				SIZE_BYTE: in_size = pos == 2'd0;
				SIZE_HALF: in_size = pos <= 2'd1;
				SIZE_WORD: in_size = 1'b1;
				SIZE_RSVD: in_size = 1'b0;
				default:   in_size = 1'b0;
			endcase
			acc.bank_act[b]   = (hit_colour || hit_mono) && in_size && ({1'b0, row} < words);
			acc.bank_row[b]   = row[ROW_W-1:0];
			acc.bank_wdata[b] = write_data[8*pos +: 8];
		end
	end

endmodule

// ===== sv/display_register_and_frame_memory_unit.sv =====
// ----------------------------------------------------------------------------
// display_register_and_frame_memory_unit: display device bus slave
// Seven-segment bytes plus colour frame store and monochrome line store.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one bus access per transfer. s_tuser is the access
//   kind (0 read, 1 write); s_tdata carries address, size code and write data.
//   Master channel m_*: one transfer per read, carrying the little-endian read
//   data. Writes return nothing and take effect at the accepting edge.
//   Each store is split into four byte-lane banks, so a misaligned access that
//   spans two words still touches each bank at most once: one access per cycle
//   while s_tready is high. A read returns its data through the bank read
//   register, then the output register. Sustained rate is one access per
//   cycle while the receiver keeps m_tready high.
//   If the receiver stalls with a result held, one more read may sit in the
//   bank read stage; after that s_tready drops until the result is taken.
//   Reset clears the segment bytes at once and then sweeps zeros through the
//   banks, one row per cycle, over max(COLOUR_ROWS*COLOUR_COLUMNS, MONO_ROWS)
//   rows (1024 by default), during which s_tready stays low.
// ----------------------------------------------------------------------------
module display_register_and_frame_memory_unit import drfm_pkg::*; #(
	parameter int COLOUR_ROWS    = COLOUR_ROWS_DEF,
	parameter int COLOUR_COLUMNS = COLOUR_COLUMNS_DEF,
	parameter int MONO_ROWS      = MONO_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // address[15:0], size_code[17:16], write_data[49:18], zero
	input  logic        s_tuser,   // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // read_data[31:0]
);

	localparam int COLOUR_WORDS = COLOUR_ROWS * COLOUR_COLUMNS;
	localparam int CAW          = (COLOUR_WORDS > 1) ? $clog2(COLOUR_WORDS) : 1;
	localparam int MAW          = (MONO_ROWS > 1) ? $clog2(MONO_ROWS) : 1;
	localparam int CLR_ROWS     = (COLOUR_WORDS > MONO_ROWS) ? COLOUR_WORDS : MONO_ROWS;
	localparam int CLW          = (CLR_ROWS > 1) ? $clog2(CLR_ROWS) : 1;
	localparam logic [CLW-1:0] CLR_LAST = CLW'(CLR_ROWS - 1);

	acc_t acc;
	logic accept;
	logic s1_adv;

	logic           clr_active_q;
	logic [CLW-1:0] clr_idx_q;

	logic [7:0] seg_left_q;
	logic [7:0] seg_right_q;

	logic        rd_s1;
	logic [15:0] seg_rd_s1;
	logic        use_mono_s1;
	logic [1:0]  off_lo_s1;
	logic [3:0]  bank_act_s1;

	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	logic [3:0]          c_en, c_we, m_en, m_we;
	logic [3:0][CAW-1:0] c_addr;
	logic [3:0][MAW-1:0] m_addr;
	logic [3:0][7:0]     c_wdata, c_rdata, m_wdata, m_rdata;
	logic [15:0]         seg_rd;
	logic [31:0]         rdata;

	drfm_decode #(
		.COLOUR_WORDS (COLOUR_WORDS),
		.MONO_WORDS   (MONO_ROWS)
	) u_decode (
		.kind       (s_tuser),
		.address    (s_tdata[15:0]),
		.size_code  (s_tdata[17:16]),
		.write_data (s_tdata[49:18]),
		.acc        (acc)
	);

	// handshake: bank stage moves on when the output register is empty or its result is being taken
	assign s1_adv   = !m_tvalid_q || m_tready;
	assign s_tready = !clr_active_q && (!rd_s1 || s1_adv);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			if (clr_idx_q == CLR_LAST) begin
				clr_active_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + CLW'(1);
			end
		end
	end

	// bank port control: sweep or bus access
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			if (clr_active_q) begin
				c_en[b]    = int'(clr_idx_q) < COLOUR_WORDS;
				c_we[b]    = 1'b1;
				c_addr[b]  = clr_idx_q[CAW-1:0];
				c_wdata[b] = '0;
				m_en[b]    = int'(clr_idx_q) < MONO_ROWS;
				m_we[b]    = 1'b1;
				m_addr[b]  = clr_idx_q[MAW-1:0];
				m_wdata[b] = '0;
			end else begin
				c_en[b]    = accept && !acc.use_mono && acc.bank_act[b] && (acc.rd || acc.wr);
				c_we[b]    = acc.wr;
				c_addr[b]  = acc.bank_row[b][CAW-1:0];
				c_wdata[b] = acc.bank_wdata[b];
				m_en[b]    = accept && acc.use_mono && acc.bank_act[b] && (acc.rd || acc.wr);
				m_we[b]    = acc.wr;
				m_addr[b]  = acc.bank_row[b][MAW-1:0];
				m_wdata[b] = acc.bank_wdata[b];
			end
		end
	end

	// byte-lane banks of both stores
	for (genvar gb = 0; gb < 4; gb++) begin : g_bank
		drfm_byte_ram #(
			.DEPTH (COLOUR_WORDS),
			.AW    (CAW)
		) u_colour (
			.clk   (clk),
			.en    (c_en[gb]),
			.we    (c_we[gb]),
			.addr  (c_addr[gb]),
			.wdata (c_wdata[gb]),
			.rdata (c_rdata[gb])
		);

		drfm_byte_ram #(
			.DEPTH (MONO_ROWS),
			.AW    (MAW)
		) u_mono (
			.clk   (clk),
			.en    (m_en[gb]),
			.we    (m_we[gb]),
			.addr  (m_addr[gb]),
			.wdata (m_wdata[gb]),
			.rdata (m_rdata[gb])
		);
	end

	// segment bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_left_q  <= '0;
			seg_right_q <= '0;
		end else if (accept && acc.wr) begin
			if (acc.seg_r) begin
				seg_right_q <= s_tdata[25:18];
				if (acc.seg_wide) begin
					seg_left_q <= s_tdata[33:26];
				end
			end else if (acc.seg_l) begin
				seg_left_q <= s_tdata[25:18];
			end
		end
	end

	// segment read value at acceptance
	always_comb begin
		priority if (acc.seg_r) begin
			seg_rd = {acc.seg_wide ? seg_left_q : 8'h00, seg_right_q};
		end else if (acc.seg_l) begin
			seg_rd = {8'h00, seg_left_q};
		end else begin
			seg_rd = '0;
		end
	end

	// bank read stage: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else if (accept) begin
			rd_s1 <= acc.rd;
		end else if (s1_adv) begin
			rd_s1 <= 1'b0;
		end
	end

	// bank read stage: lane mapping and segment data
	always_ff @(posedge clk) begin
		if (accept) begin
			seg_rd_s1   <= seg_rd;
			use_mono_s1 <= acc.use_mono;
			off_lo_s1   <= acc.off_lo;
			bank_act_s1 <= acc.rd ? acc.bank_act : 4'b0000;
		end
	end

	// gather the read bytes in access order
	always_comb begin
		logic [1:0] b;
		rdata = {16'h0000, seg_rd_s1};
		for (int i = 0; i < 4; i++) begin
			b = off_lo_s1 + 2'(i);
			if (bank_act_s1[b]) begin
				rdata[8*i +: 8] = use_mono_s1 ? m_rdata[b] : c_rdata[b];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_adv) begin
			m_tvalid_q <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && rd_s1) begin
			m_tdata_q <= rdata;
		end
	end

	// a read held in the bank stage is not lost while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 && !s1_adv |=> rd_s1)
		else $error("bank read stage dropped a read");

	// an accepted read always reaches the bank stage
	a_read_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept && acc.rd |=> rd_s1)
		else $error("accepted read not staged");

	// the two stores are never accessed by the same transfer
	a_one_store: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_active_q |-> !((|c_en) && (|m_en)))
		else $error("both stores enabled by one access");

	// no transfer accepted during the clearing sweep
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !accept)
		else $error("transfer accepted while clearing");

endmodule
